FILE: hdl/first_fit_heap_allocator_defines.svh
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// expr must never be true outside reset
`define FFHA_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ffha assertion failed");
// ante implies cons in the same cycle
`define FFHA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffha assertion failed");
`else
`define FFHA_ASSERT_NEVER(label, expr)
`define FFHA_ASSERT_IMP(label, ante, cons)
`endif

`endif

FILE: hdl/ffha_pkg.sv
// Constants, widths and sequencer states of the first-fit heap allocator.
package ffha_pkg;

    localparam int HEAP_UNITS = 1024;
    localparam int UNIT_BYTES = 8;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);

    localparam int ADDR_W  = $clog2(HEAP_UNITS);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int BYTES_W = 16;
    localparam int NEED_W  = BYTES_W - UNIT_SHIFT + 2;
    localparam int ALU_W   = BYTES_W + 1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [CNT_W-1:0] NIL = CNT_W'(HEAP_UNITS);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_START,
        ST_A_CHECK,
        ST_A_WAIT,
        ST_A_SPLIT,
        ST_A_TAKE,
        ST_F_START,
        ST_F_SZ,
        ST_F_HEADMERGE,
        ST_F_CHECK,
        ST_F_WALK,
        ST_F_GROW,
        ST_F_GSUM,
        ST_F_UPCHK,
        ST_F_UPMERGE,
        ST_F_AFTER,
        ST_F_TAIL,
        ST_F_LOMERGE,
        ST_F_ADD,
        ST_DONE
    } ffha_state_t;

endpackage

FILE: hdl/first_fit_heap_allocator.sv
// First-fit heap allocator: header memory, list-walk sequencer and shared adder.
// An allocate reads the header and runs the fit test of each free block visited,
// besides the accept, setup, free count and result steps, and one more step when
// the block is split; a free reads and checks the header of each free block walked
// below the freed block, besides the accept, the header check, linking, merging,
// the free count and the result. The walk rate is set by the single read port of
// the header memory and its registered read data; most sums and the fit test go
// through one adder. No clearing pass is needed after reset. The block takes
// one request at a time and accepts the next request as soon as the previous
// result is in the output register, even while that result still waits to be
// taken; a result that finds the output register full waits until it is taken.
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] request_bytes, [25:16] block_address, [31:26] zero
    input  logic [ffha_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] func
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] granted_address, [20:10] units_left, [23:21] zero
    output logic [ffha_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] status
    output logic                              m_tuser
);
    import ffha_pkg::*;

    ffha_state_t state_reg, state_next;

    logic                 func_reg, func_next;
    logic [BYTES_W-1:0]   bytes_reg, bytes_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [ADDR_W-1:0]    f_reg, f_next;
    logic [NEED_W-1:0]    need_reg, need_next;
    logic [CNT_W-1:0]     sz_reg, sz_next;
    logic [CNT_W-1:0]     cur_reg, cur_next;
    logic [CNT_W-1:0]     prev_reg, prev_next;
    logic [CNT_W-1:0]     steps_reg, steps_next;
    logic [CNT_W-1:0]     link_reg, link_next;
    logic [CNT_W-1:0]     nsize_reg, nsize_next;
    logic [CNT_W:0]       tmp_reg, tmp_next;
    logic [CNT_W-1:0]     free_head_reg, free_head_next;
    logic [CNT_W-1:0]     units_free_reg, units_free_next;
    logic [ADDR_W-1:0]    granted_reg, granted_next;
    logic                 status_reg, status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    out_granted_reg, out_granted_next;
    logic [CNT_W-1:0]     out_left_reg, out_left_next;
    logic                 out_status_reg, out_status_next;
    logic                 link0_ok_reg, link0_ok_next;
    logic                 size0_ok_reg, size0_ok_next;

    // header memory, link and size kept as separate arrays on one address
    logic [CNT_W-1:0]     link_mem [HEAP_UNITS];
    logic [CNT_W-1:0]     size_mem [HEAP_UNITS];
    logic [CNT_W-1:0]     link_q, size_q;
    logic [ADDR_W-1:0]    rd_addr_q;
    logic                 rd_en, wr_link_en, wr_size_en;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic [CNT_W-1:0]     wr_link, wr_size;
    logic [CNT_W-1:0]     hdr_link, hdr_size;

    // shared adder
    logic [ALU_W-1:0]     alu_a, alu_b, alu_res;
    logic                 alu_sub;

    logic                 in_beat, out_free;
    logic [BYTES_W-1:0]   bytes_adj;
    logic                 fits, exact, walk_more, alloc_more, bad_size, end_hit;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(OUT_DATA_W - ADDR_W - CNT_W)'(0), out_left_reg, out_granted_reg};

    // entry 0 holds the whole heap until first written
    assign hdr_link = (rd_addr_q == '0 && !link0_ok_reg) ? NIL : link_q;
    assign hdr_size = (rd_addr_q == '0 && !size0_ok_reg) ? NIL : size_q;

    assign bytes_adj = (bytes_reg == '0) ? BYTES_W'(1) : bytes_reg;

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_A_START:
            begin
                alu_a = ALU_W'(bytes_adj);
                alu_b = ALU_W'(UNIT_BYTES - 1);
            end
            ST_A_WAIT:
            begin
                alu_a   = ALU_W'(hdr_size);
                alu_b   = ALU_W'(need_reg);
                alu_sub = 1'b1;
            end
            ST_A_SPLIT:
            begin
                alu_a = ALU_W'(cur_reg);
                alu_b = ALU_W'(tmp_reg);
            end
            ST_A_TAKE:
            begin
                alu_a   = ALU_W'(units_free_reg);
                alu_b   = ALU_W'(need_reg);
                alu_sub = 1'b1;
            end
            ST_F_SZ:
            begin
                alu_a = ALU_W'(f_reg);
                alu_b = ALU_W'(hdr_size);
            end
            ST_F_HEADMERGE, ST_F_LOMERGE:
            begin
                alu_a = ALU_W'(sz_reg);
                alu_b = ALU_W'(hdr_size);
            end
            ST_F_WALK:
            begin
                alu_a = ALU_W'(cur_reg);
                alu_b = ALU_W'(hdr_size);
            end
            ST_F_GROW:
            begin
                alu_a = ALU_W'(tmp_reg);
                alu_b = ALU_W'(sz_reg);
            end
            ST_F_GSUM:
            begin
                alu_a = ALU_W'(cur_reg);
                alu_b = ALU_W'(nsize_reg);
            end
            ST_F_UPMERGE:
            begin
                alu_a = ALU_W'(nsize_reg);
                alu_b = ALU_W'(hdr_size);
            end
            ST_F_TAIL:
            begin
                alu_a = ALU_W'(f_reg);
                alu_b = ALU_W'(sz_reg);
            end
            ST_F_ADD:
            begin
                alu_a = ALU_W'(units_free_reg);
                alu_b = ALU_W'(sz_reg);
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    assign fits       = !alu_res[ALU_W-1];
    assign exact      = (alu_res == '0);
    assign bad_size   = (hdr_size == '0) || (alu_res > ALU_W'(HEAP_UNITS));
    assign end_hit    = (alu_res == ALU_W'(f_reg));
    assign alloc_more = (cur_reg < NIL) && (steps_reg <= NIL);
    assign walk_more  = (cur_reg < NIL) && (cur_reg < CNT_W'(f_reg)) && (steps_reg <= NIL);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = (s_tuser == FUNC_FREE) ? ST_F_START : ST_A_START;
                end
            end
            ST_A_START:
            begin
                state_next = ST_A_CHECK;
            end
            ST_A_CHECK:
            begin
                state_next = alloc_more ? ST_A_WAIT : ST_DONE;
            end
            ST_A_WAIT:
            begin
                if (!fits)
                begin
                    state_next = ST_A_CHECK;
                end
                else if (exact)
                begin
                    state_next = ST_A_TAKE;
                end
                else
                begin
                    state_next = ST_A_SPLIT;
                end
            end
            ST_A_SPLIT:
            begin
                state_next = ST_A_TAKE;
            end
            ST_A_TAKE:
            begin
                state_next = ST_DONE;
            end
            ST_F_START:
            begin
                state_next = (addr_reg == '0) ? ST_DONE : ST_F_SZ;
            end
            ST_F_SZ:
            begin
                if (bad_size)
                begin
                    state_next = ST_DONE;
                end
                else if (free_head_reg >= NIL)
                begin
                    state_next = ST_F_ADD;
                end
                else if (free_head_reg == CNT_W'(f_reg))
                begin
                    state_next = ST_DONE;
                end
                else if (free_head_reg > CNT_W'(f_reg))
                begin
                    state_next = (alu_res == ALU_W'(free_head_reg)) ? ST_F_HEADMERGE
                                                                     : ST_F_ADD;
                end
                else
                begin
                    state_next = ST_F_CHECK;
                end
            end
            ST_F_HEADMERGE, ST_F_UPMERGE, ST_F_LOMERGE:
            begin
                state_next = ST_F_ADD;
            end
            ST_F_CHECK:
            begin
                state_next = walk_more ? ST_F_WALK : ST_F_AFTER;
            end
            ST_F_WALK:
            begin
                state_next = end_hit ? ST_F_GROW : ST_F_CHECK;
            end
            ST_F_GROW:
            begin
                state_next = ST_F_GSUM;
            end
            ST_F_GSUM:
            begin
                state_next = ST_F_UPCHK;
            end
            ST_F_UPCHK:
            begin
                if (tmp_reg < (CNT_W+1)'(NIL) && tmp_reg == (CNT_W+1)'(link_reg))
                begin
                    state_next = ST_F_UPMERGE;
                end
                else
                begin
                    state_next = ST_F_ADD;
                end
            end
            ST_F_AFTER:
            begin
                if (prev_reg >= NIL || cur_reg == CNT_W'(f_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_F_TAIL;
                end
            end
            ST_F_TAIL:
            begin
                if (cur_reg < NIL && alu_res == ALU_W'(cur_reg))
                begin
                    state_next = ST_F_LOMERGE;
                end
                else
                begin
                    state_next = ST_F_ADD;
                end
            end
            ST_F_ADD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        func_next        = func_reg;
        bytes_next       = bytes_reg;
        addr_next        = addr_reg;
        f_next           = f_reg;
        need_next        = need_reg;
        sz_next          = sz_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        steps_next       = steps_reg;
        link_next        = link_reg;
        nsize_next       = nsize_reg;
        tmp_next         = tmp_reg;
        free_head_next   = free_head_reg;
        units_free_next  = units_free_reg;
        granted_next     = granted_reg;
        status_next      = status_reg;
        out_granted_next = out_granted_reg;
        out_left_next    = out_left_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        rd_en            = 1'b0;
        rd_addr          = cur_reg[ADDR_W-1:0];
        wr_link_en       = 1'b0;
        wr_size_en       = 1'b0;
        wr_addr          = cur_reg[ADDR_W-1:0];
        wr_link          = NIL;
        wr_size          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    func_next    = s_tuser;
                    bytes_next   = s_tdata[BYTES_W-1:0];
                    addr_next    = s_tdata[BYTES_W +: ADDR_W];
                    status_next  = STATUS_OK;
                    granted_next = '0;
                    cur_next     = free_head_reg;
                    prev_next    = NIL;
                    steps_next   = '0;
                end
            end
            ST_A_START:
            begin
                need_next = NEED_W'(alu_res >> UNIT_SHIFT) + NEED_W'(1);
            end
            ST_A_CHECK:
            begin
                if (alloc_more)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            ST_A_WAIT:
            begin
                if (!fits)
                begin
                    prev_next  = cur_reg;
                    cur_next   = hdr_link;
                    steps_next = steps_reg + CNT_W'(1);
                end
                else if (exact)
                begin
                    if (prev_reg >= NIL)
                    begin
                        free_head_next = hdr_link;
                    end
                    else
                    begin
                        wr_link_en = 1'b1;
                        wr_addr    = prev_reg[ADDR_W-1:0];
                        wr_link    = hdr_link;
                    end
                    granted_next = cur_reg[ADDR_W-1:0] + ADDR_W'(1);
                end
                else
                begin
                    // split: the low part stays free, the top end is handed out
                    wr_size_en = 1'b1;
                    wr_size    = alu_res[CNT_W-1:0];
                    tmp_next   = alu_res[CNT_W:0];
                end
            end
            ST_A_SPLIT:
            begin
                wr_size_en   = 1'b1;
                wr_addr      = alu_res[ADDR_W-1:0];
                wr_size      = CNT_W'(need_reg);
                granted_next = alu_res[ADDR_W-1:0] + ADDR_W'(1);
            end
            ST_A_TAKE:
            begin
                units_free_next = alu_res[ALU_W-1] ? '0 : alu_res[CNT_W-1:0];
            end
            ST_F_START:
            begin
                f_next  = addr_reg - ADDR_W'(1);
                rd_en   = (addr_reg != '0);
                rd_addr = addr_reg - ADDR_W'(1);
            end
            ST_F_SZ:
            begin
                sz_next = hdr_size;
                if (!bad_size)
                begin
                    if (free_head_reg >= NIL)
                    begin
                        free_head_next = CNT_W'(f_reg);
                        wr_link_en     = 1'b1;
                        wr_addr        = f_reg;
                        wr_link        = NIL;
                    end
                    else if (free_head_reg > CNT_W'(f_reg))
                    begin
                        free_head_next = CNT_W'(f_reg);
                        if (alu_res == ALU_W'(free_head_reg))
                        begin
                            rd_en   = 1'b1;
                            rd_addr = free_head_reg[ADDR_W-1:0];
                        end
                        else
                        begin
                            wr_link_en = 1'b1;
                            wr_addr    = f_reg;
                            wr_link    = free_head_reg;
                        end
                    end
                end
            end
            ST_F_HEADMERGE, ST_F_LOMERGE:
            begin
                wr_link_en = 1'b1;
                wr_size_en = 1'b1;
                wr_addr    = f_reg;
                wr_link    = hdr_link;
                wr_size    = alu_res[CNT_W-1:0];
            end
            ST_F_CHECK:
            begin
                rd_en = walk_more;
            end
            ST_F_WALK:
            begin
                if (end_hit)
                begin
                    tmp_next  = (CNT_W+1)'(hdr_size);
                    link_next = hdr_link;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = hdr_link;
                    steps_next = steps_reg + CNT_W'(1);
                end
            end
            ST_F_GROW:
            begin
                nsize_next = alu_res[CNT_W-1:0];
                wr_size_en = 1'b1;
                wr_size    = alu_res[CNT_W-1:0];
            end
            ST_F_GSUM:
            begin
                tmp_next = alu_res[CNT_W:0];
            end
            ST_F_UPCHK:
            begin
                rd_en   = (tmp_reg < (CNT_W+1)'(NIL)) && (tmp_reg == (CNT_W+1)'(link_reg));
                rd_addr = tmp_reg[ADDR_W-1:0];
            end
            ST_F_UPMERGE:
            begin
                wr_link_en = 1'b1;
                wr_size_en = 1'b1;
                wr_link    = hdr_link;
                wr_size    = alu_res[CNT_W-1:0];
            end
            ST_F_AFTER:
            begin
                if (prev_reg < NIL && cur_reg != CNT_W'(f_reg))
                begin
                    wr_link_en = 1'b1;
                    wr_addr    = prev_reg[ADDR_W-1:0];
                    wr_link    = CNT_W'(f_reg);
                end
            end
            ST_F_TAIL:
            begin
                if (cur_reg < NIL && alu_res == ALU_W'(cur_reg))
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    wr_link_en = 1'b1;
                    wr_addr    = f_reg;
                    wr_link    = (cur_reg < NIL) ? cur_reg : NIL;
                end
            end
            ST_F_ADD:
            begin
                units_free_next = (alu_res > ALU_W'(HEAP_UNITS)) ? NIL : alu_res[CNT_W-1:0];
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = status_reg;
                    out_granted_next = granted_reg;
                    out_left_next    = units_free_reg;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign link0_ok_next = link0_ok_reg || (wr_link_en && wr_addr == '0);
    assign size0_ok_next = size0_ok_reg || (wr_size_en && wr_addr == '0);

    always_ff @(posedge clk)
    begin
        if (wr_link_en)
        begin
            link_mem[wr_addr] <= wr_link;
        end
        if (wr_size_en)
        begin
            size_mem[wr_addr] <= wr_size;
        end
        if (rd_en)
        begin
            link_q    <= link_mem[rd_addr];
            size_q    <= size_mem[rd_addr];
            rd_addr_q <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            free_head_reg   <= '0;
            units_free_reg  <= NIL;
            out_valid_reg   <= 1'b0;
            link0_ok_reg    <= 1'b0;
            size0_ok_reg    <= 1'b0;
            steps_reg       <= '0;
            cur_reg         <= '0;
            prev_reg        <= NIL;
            status_reg      <= STATUS_OK;
            granted_reg     <= '0;
            func_reg        <= FUNC_ALLOC;
        end
        else
        begin
            state_reg       <= state_next;
            free_head_reg   <= free_head_next;
            units_free_reg  <= units_free_next;
            out_valid_reg   <= out_valid_next;
            link0_ok_reg    <= link0_ok_next;
            size0_ok_reg    <= size0_ok_next;
            steps_reg       <= steps_next;
            cur_reg         <= cur_next;
            prev_reg        <= prev_next;
            status_reg      <= status_next;
            granted_reg     <= granted_next;
            func_reg        <= func_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bytes_reg       <= bytes_next;
        addr_reg        <= addr_next;
        f_reg           <= f_next;
        need_reg        <= need_next;
        sz_reg          <= sz_next;
        link_reg        <= link_next;
        nsize_reg       <= nsize_next;
        tmp_reg         <= tmp_next;
        out_granted_reg <= out_granted_next;
        out_left_reg    <= out_left_next;
        out_status_reg  <= out_status_next;
    end

    `FFHA_ASSERT_NEVER(a_free_count_max, units_free_reg > NIL)
    `FFHA_ASSERT_NEVER(a_steps_bound, steps_reg > NIL + CNT_W'(1))
    `FFHA_ASSERT_IMP(a_fail_only_alloc, state_reg == ST_DONE && status_reg == STATUS_FULL, func_reg == FUNC_ALLOC && granted_reg == '0)
    `FFHA_ASSERT_IMP(a_grant_nonzero, state_reg == ST_DONE && func_reg == FUNC_ALLOC && status_reg == STATUS_OK, granted_reg != '0)
    `FFHA_ASSERT_IMP(a_free_no_grant, state_reg == ST_DONE && func_reg == FUNC_FREE, granted_reg == '0 && status_reg == STATUS_OK)

endmodule
